// ----- design/frp_pkg.sv -----
// ----------------------------------------------------------------------------
// FASTQ record parser package
// Shared widths, result kinds, error codes and beat structures.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned RecIdxW = 32;
  localparam int unsigned LenW    = 16;

  localparam longint unsigned MaxLineDefault = 65535;

  localparam logic [KindW-1:0] KindLabel = 3'd0;
  localparam logic [KindW-1:0] KindDrop  = 3'd1;
  localparam logic [KindW-1:0] KindBase  = 3'd2;
  localparam logic [KindW-1:0] KindPlus  = 3'd3;
  localparam logic [KindW-1:0] KindQual  = 3'd4;
  localparam logic [KindW-1:0] KindEol   = 3'd5;
  localparam logic [KindW-1:0] KindEnd   = 3'd6;
  localparam logic [KindW-1:0] KindErr   = 3'd7;

  localparam logic [ErrW-1:0] ErrNone     = 3'd0;
  localparam logic [ErrW-1:0] ErrEmpty    = 3'd1;
  localparam logic [ErrW-1:0] ErrNoAt     = 3'd2;
  localparam logic [ErrW-1:0] ErrLetter   = 3'd3;
  localparam logic [ErrW-1:0] ErrNonPrint = 3'd4;
  localparam logic [ErrW-1:0] ErrEarlyEof = 3'd5;
  localparam logic [ErrW-1:0] ErrLength   = 3'd6;
  localparam logic [ErrW-1:0] ErrOverflow = 3'd7;

  localparam logic [ByteW-1:0] CharNewline = 8'h0A;
  localparam logic [ByteW-1:0] CharAt      = 8'h40;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   value;
    logic [ErrW-1:0]    error_code;
    logic [RecIdxW-1:0] record_index;
    logic [LenW-1:0]    seq_length;
    logic               record_done;
    logic               stream_done;
  } out_item_t;

endpackage

// ----- design/frp_if.sv -----
// ----------------------------------------------------------------------------
// FASTQ record parser channels
// Valid/ready channels for input bytes and for classified result beats.
// ----------------------------------------------------------------------------
interface frp_in_if;
  import frp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_value;
  logic             end_of_input;

  modport source (output valid, output byte_value, output end_of_input, input ready);
  modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface frp_out_if;
  import frp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [ByteW-1:0]   value;
  logic [ErrW-1:0]    error_code;
  logic [RecIdxW-1:0] record_index;
  logic [LenW-1:0]    seq_length;
  logic               record_done;
  logic               stream_done;

  modport source (output valid, output kind, output value, output error_code,
                  output record_index, output seq_length, output record_done,
                  output stream_done, input ready);
  modport sink   (input valid, input kind, input value, input error_code,
                  input record_index, input seq_length, input record_done,
                  input stream_done, output ready);
endinterface

// ----- design/frp_in_reg.sv -----
// ----------------------------------------------------------------------------
// FASTQ parser input register
// Holds one accepted byte beat until the parse stage takes it.
// ----------------------------------------------------------------------------
module frp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  frp_pkg::in_item_t item_i,
  output logic              full_o,
  output frp_pkg::in_item_t item_o,
  input  logic              take_i
);
  import frp_pkg::*;

  logic     full_q;
  logic     full_d;
  in_item_t item_q;
  logic     load;

  assign ready_o = !full_q || take_i;
  assign load    = valid_i && ready_o;
  assign full_d  = load || (full_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign full_o = full_q;
  assign item_o = item_q;

endmodule

// ----- design/frp_parse.sv -----
// ----------------------------------------------------------------------------
// FASTQ parser record tracker
// Classifies one byte per cycle against the record state and updates it while step_i is high.
// ----------------------------------------------------------------------------
module frp_parse #(
  parameter longint unsigned MaxLine = frp_pkg::MaxLineDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               trunc_i,
  input  frp_pkg::in_item_t  item_i,
  output frp_pkg::out_item_t result_o
);
  import frp_pkg::*;

  localparam logic [LenW-1:0] LineLimit =
    (MaxLine < 64'd65535) ? MaxLine[LenW-1:0] : {LenW{1'b1}};

  localparam logic [2:0] PhLabel = 3'd0;
  localparam logic [2:0] PhSeq   = 3'd1;
  localparam logic [2:0] PhPlus  = 3'd2;
  localparam logic [2:0] PhQual  = 3'd3;
  localparam logic [2:0] PhEmpty = 3'd4;
  localparam logic [2:0] PhEnd   = 3'd5;

  logic [2:0]         phase_q, phase_d;
  logic               start_q, start_d;
  logic               cut_q, cut_d;
  logic [LenW-1:0]    line_cnt_q, line_cnt_d;
  logic [LenW-1:0]    seq_len_q, seq_len_d;
  logic [RecIdxW-1:0] rec_cnt_q, rec_cnt_d;
  logic [ErrW-1:0]    sticky_q, sticky_d;

  logic [KindW-1:0] kind;
  logic [ByteW-1:0] val;
  logic [ErrW-1:0]  err;
  logic             rdone;
  logic             sdone;
  logic             new_line;
  logic [ByteW-1:0] b;

  function automatic logic is_ws(logic [ByteW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_letter(logic [ByteW-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  assign b = item_i.byte_value;

  always_comb begin
    kind       = KindErr;
    val        = '0;
    err        = ErrNone;
    rdone      = 1'b0;
    sdone      = 1'b0;
    new_line   = 1'b0;
    phase_d    = phase_q;
    start_d    = start_q;
    cut_d      = cut_q;
    line_cnt_d = line_cnt_q;
    seq_len_d  = seq_len_q;
    rec_cnt_d  = rec_cnt_q;
    sticky_d   = sticky_q;

    if (sticky_q != ErrNone) begin
      err = sticky_q;
    end else if (phase_q == PhEnd) begin
      kind  = KindEnd;
      sdone = 1'b1;
    end else if (item_i.end_of_input) begin
      if ((phase_q == PhLabel && start_q) || phase_q == PhEmpty) begin
        kind  = KindEnd;
        sdone = 1'b1;
      end else if (phase_q == PhQual && !start_q) begin
        if (line_cnt_q == seq_len_q) begin
          kind      = KindEnd;
          rdone     = 1'b1;
          sdone     = 1'b1;
          rec_cnt_d = rec_cnt_q + 1'b1;
        end else begin
          err = ErrLength;
        end
      end else begin
        err = ErrEarlyEof;
      end
      if (err == ErrNone) begin
        phase_d  = PhEnd;
        new_line = 1'b1;
      end
    end else if (b == CharNewline) begin
      kind = KindEol;
      case (phase_q)
        PhLabel: begin
          phase_d = start_q ? PhEmpty : PhSeq;
        end
        PhSeq: begin
          phase_d = PhPlus;
        end
        PhPlus: begin
          phase_d = PhQual;
        end
        PhQual: begin
          if (line_cnt_q == seq_len_q) begin
            rdone     = 1'b1;
            rec_cnt_d = rec_cnt_q + 1'b1;
            phase_d   = PhLabel;
          end else begin
            err = ErrLength;
          end
        end
        default: begin
        end
      endcase
      if (err == ErrNone) begin
        new_line = 1'b1;
      end
    end else if (phase_q == PhEmpty) begin
      err = ErrEmpty;
    end else if (line_cnt_q >= LineLimit) begin
      err = ErrOverflow;
    end else begin
      val = b;
      case (phase_q)
        PhLabel: begin
          if (start_q) begin
            if (b != CharAt) begin
              err = ErrNoAt;
            end else begin
              kind      = KindDrop;
              seq_len_d = '0;
            end
          end else if (cut_q || (trunc_i && is_ws(b))) begin
            cut_d = 1'b1;
            kind  = KindDrop;
          end else begin
            kind = KindLabel;
          end
        end
        PhSeq: begin
          if (is_letter(b)) begin
            kind      = KindBase;
            seq_len_d = line_cnt_q + 1'b1;
          end else begin
            err = (b >= 8'h20 && b <= 8'h7E) ? ErrLetter : ErrNonPrint;
          end
        end
        PhPlus: begin
          kind = KindPlus;
        end
        default: begin
          kind = KindQual;
        end
      endcase
      if (err == ErrNone) begin
        start_d    = 1'b0;
        line_cnt_d = line_cnt_q + 1'b1;
      end
    end

    if (new_line) begin
      start_d    = 1'b1;
      line_cnt_d = '0;
      cut_d      = 1'b0;
    end

    if (err != ErrNone) begin
      sticky_d = err;
      kind     = KindErr;
      val      = '0;
      rdone    = 1'b0;
      sdone    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhLabel;
      start_q    <= 1'b1;
      cut_q      <= 1'b0;
      line_cnt_q <= '0;
      seq_len_q  <= '0;
      rec_cnt_q  <= '0;
      sticky_q   <= ErrNone;
    end else if (step_i) begin
      phase_q    <= phase_d;
      start_q    <= start_d;
      cut_q      <= cut_d;
      line_cnt_q <= line_cnt_d;
      seq_len_q  <= seq_len_d;
      rec_cnt_q  <= rec_cnt_d;
      sticky_q   <= sticky_d;
    end
  end

  assign result_o.kind         = kind;
  assign result_o.value        = val;
  assign result_o.error_code   = err;
  assign result_o.record_index = rec_cnt_q;
  assign result_o.seq_length   = seq_len_d;
  assign result_o.record_done  = rdone;
  assign result_o.stream_done  = sdone;

endmodule

// ----- design/fastq_record_parser.sv -----
// ----------------------------------------------------------------------------
// FASTQ record parser
// Streams FASTQ text one byte per beat and emits one classified beat each.
// ----------------------------------------------------------------------------
// The in_i channel carries one text byte per beat, or an end-of-input mark.
// Every input beat yields exactly one result beat on out_o, in order, giving
// its kind, the passed byte, any error code, the record index, the current
// sequence length and record/stream completion flags.
// cfg_we_i with cfg_data_i writes the label truncation enable; write it only
// while the parser is idle.
// An accepted beat passes the input register and the single parse stage,
// which reads and updates the record state in the same cycle, into the
// output register; one beat per cycle is taken unless out_o stalls.
// The input register keeps taking beats while a finished result waits in
// the output register; when the receiver stalls, both registers fill and
// in_i.ready drops until out_o.ready returns.
// Reset clears both registers, the record state, the record counter, the
// sticky error and the truncation enable; the parser expects a label line.
// ----------------------------------------------------------------------------
module fastq_record_parser #(
  parameter longint unsigned MaxLine = frp_pkg::MaxLineDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_data_i,
  frp_in_if.sink    in_i,
  frp_out_if.source out_o
);
  import frp_pkg::*;

  logic      trunc_q;
  logic      in_full;
  in_item_t  in_item;
  in_item_t  stage_item;
  logic      take;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;

  assign in_item.byte_value   = in_i.byte_value;
  assign in_item.end_of_input = in_i.end_of_input;

  assign take = in_full && (!out_valid_q || out_o.ready);

  frp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .full_o  (in_full),
    .item_o  (stage_item),
    .take_i  (take)
  );

  frp_parse #(
    .MaxLine (MaxLine)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .trunc_i  (trunc_q),
    .item_i   (stage_item),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= 1'b0;
    end else if (cfg_we_i) begin
      trunc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.value        = out_q.value;
  assign out_o.error_code   = out_q.error_code;
  assign out_o.record_index = out_q.record_index;
  assign out_o.seq_length   = out_q.seq_length;
  assign out_o.record_done  = out_q.record_done;
  assign out_o.stream_done  = out_q.stream_done;

  a_err_code_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.kind == KindErr) == (out_q.error_code != ErrNone)))
    else $error("error code and error kind disagree");

  a_record_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.record_done) |-> (out_q.kind == KindEol || out_q.kind == KindEnd))
    else $error("record completion on a non-terminating beat");

  a_stream_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.stream_done) |-> (out_q.kind == KindEnd))
    else $error("stream completion without end kind");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.ready && out_q.kind == KindErr)
      |=> (!out_valid_q || out_q.kind == KindErr))
    else $error("error did not persist");

endmodule

// ----- bench/tb_fastq_record_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTQ record parser testbench
// Feeds FASTQ text beat by beat with random idling on both channels. A
// scoreboard class models the parser state and checks every result beat in
// order. Well-formed records with random content form most of the stream;
// each run then closes with one randomly chosen ending, clean or erroneous,
// followed by noise beats that must keep the final status.
// ----------------------------------------------------------------------------
module tb_fastq_record_parser;
  import frp_pkg::*;

  localparam int unsigned LineLimit = (MaxLineDefault < 65535) ? int'(MaxLineDefault) : 65535;
  localparam int unsigned RandomBeats = 1000;
  localparam int unsigned NoiseBeats  = 20;

  localparam logic [ByteW-1:0] CharTab   = 8'h09;
  localparam logic [ByteW-1:0] CharCr    = 8'h0D;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B;

  typedef enum logic [2:0] {
    PhLabel, PhSeq, PhPlus, PhQual, PhEmpty, PhEnd
  } parse_phase_e;

  typedef enum int {
    EndClean, EndOpenQual, EndEmptyTail, EndEmptyThenText, EndNoAt,
    EndBadLetter, EndNonPrint, EndEarlyEof, EndLength
  } ending_e;

  class fastq_scoreboard;
    bit                 trunc;
    parse_phase_e       phase;
    bit                 line_start;
    bit                 cut;
    logic [LenW-1:0]    line_len;
    logic [LenW-1:0]    seq_len;
    logic [RecIdxW-1:0] rec_count;
    logic [ErrW-1:0]    sticky;
    out_item_t          pending[$];
    int                 failures;

    function new();
      trunc     = 1'b0;
      phase     = PhLabel;
      seq_len   = '0;
      rec_count = '0;
      sticky    = ErrNone;
      failures  = 0;
      start_line();
    endfunction

    function void start_line();
      line_start = 1'b1;
      line_len   = '0;
      cut        = 1'b0;
    endfunction

    function bit is_space(logic [ByteW-1:0] c);
      return c == CharSpace || (c >= CharTab && c <= CharCr);
    endfunction

    function bit is_letter(logic [ByteW-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function void note_input(logic [ByteW-1:0] b, logic eoi);
      out_item_t        want;
      logic [ErrW-1:0]  err;
      logic [KindW-1:0] kind;
      logic [ByteW-1:0] val;
      bit               rdone;
      bit               sdone;
      want  = '0;
      want.record_index = rec_count;
      err   = ErrNone;
      kind  = KindErr;
      val   = '0;
      rdone = 1'b0;
      sdone = 1'b0;
      if (sticky != ErrNone) begin
        err = sticky;
      end else if (phase == PhEnd) begin
        kind  = KindEnd;
        sdone = 1'b1;
      end else if (eoi) begin
        if ((phase == PhLabel && line_start) || phase == PhEmpty) begin
          kind  = KindEnd;
          sdone = 1'b1;
        end else if (phase == PhQual && !line_start) begin
          if (line_len == seq_len) begin
            kind      = KindEnd;
            rdone     = 1'b1;
            sdone     = 1'b1;
            rec_count = rec_count + 1'b1;
          end else begin
            err = ErrLength;
          end
        end else begin
          err = ErrEarlyEof;
        end
        if (err == ErrNone) begin
          phase = PhEnd;
          start_line();
        end
      end else if (b == CharNewline) begin
        kind = KindEol;
        case (phase)
          PhLabel: phase = line_start ? PhEmpty : PhSeq;
          PhSeq:   phase = PhPlus;
          PhPlus:  phase = PhQual;
          PhQual: begin
            if (line_len == seq_len) begin
              rdone     = 1'b1;
              rec_count = rec_count + 1'b1;
              phase     = PhLabel;
            end else begin
              err = ErrLength;
            end
          end
          default: ;
        endcase
        if (err == ErrNone) start_line();
      end else if (phase == PhEmpty) begin
        err = ErrEmpty;
      end else if (32'(line_len) >= LineLimit) begin
        err = ErrOverflow;
      end else begin
        val = b;
        case (phase)
          PhLabel: begin
            if (line_start) begin
              if (b != CharAt) begin
                err = ErrNoAt;
              end else begin
                kind    = KindDrop;
                seq_len = '0;
              end
            end else if (cut || (trunc && is_space(b))) begin
              cut  = 1'b1;
              kind = KindDrop;
            end else begin
              kind = KindLabel;
            end
          end
          PhSeq: begin
            if (is_letter(b)) begin
              kind    = KindBase;
              seq_len = line_len + 1'b1;
            end else begin
              err = (b >= 8'h20 && b <= 8'h7E) ? ErrLetter : ErrNonPrint;
            end
          end
          PhPlus:  kind = KindPlus;
          default: kind = KindQual;
        endcase
        if (err == ErrNone) begin
          line_start = 1'b0;
          line_len   = line_len + 1'b1;
        end
      end
      if (err != ErrNone) begin
        sticky = err;
        kind   = KindErr;
        val    = '0;
        rdone  = 1'b0;
        sdone  = 1'b0;
      end
      want.kind        = kind;
      want.value       = val;
      want.error_code  = err;
      want.seq_length  = seq_len;
      want.record_done = rdone;
      want.stream_done = sdone;
      pending.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual kind %0h",
                 $time, got.kind);
        failures++;
        return;
      end
      want = pending.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("value", 32'(want.value), 32'(got.value));
      compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
      compare_field("record_index", want.record_index, got.record_index);
      compare_field("seq_length", 32'(want.seq_length), 32'(got.seq_length));
      compare_field("record_done", 32'(want.record_done), 32'(got.record_done));
      compare_field("stream_done", 32'(want.stream_done), 32'(got.stream_done));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;

  frp_in_if  in_bus ();
  frp_out_if out_bus ();

  fastq_scoreboard sb;
  int unsigned     beats_sent;
  bit              send_quiet;
  bit              recv_quiet;

  fastq_record_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_input(in_bus.byte_value, in_bus.end_of_input);
  end

  always @(posedge clk) begin
    out_item_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.kind         = out_bus.kind;
      got.value        = out_bus.value;
      got.error_code   = out_bus.error_code;
      got.record_index = out_bus.record_index;
      got.seq_length   = out_bus.seq_length;
      got.record_done  = out_bus.record_done;
      got.stream_done  = out_bus.stream_done;
      sb.check_result(got);
    end
  end

  function automatic logic [ByteW-1:0] rand_non_nl();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 254));
    if (b >= CharNewline) b = b + 1;
    return b;
  endfunction

  function automatic logic [ByteW-1:0] rand_letter();
    int unsigned idx;
    idx = $urandom_range(0, 51);
    return (idx < 26) ? ByteW'(8'h41 + idx) : ByteW'(8'h61 + idx - 26);
  endfunction

  function automatic logic [ByteW-1:0] rand_label_byte();
    logic [ByteW-1:0] spaces[5];
    spaces = '{CharTab, 8'h0B, 8'h0C, CharCr, CharSpace};
    if ($urandom_range(0, 3) == 0) return spaces[$urandom_range(0, 4)];
    return rand_non_nl();
  endfunction

  task automatic send_beat(input logic [ByteW-1:0] b, input logic eoi);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.byte_value   <= b;
    in_bus.end_of_input <= eoi;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    beats_sent++;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
  endtask

  task automatic send_eoi();
    send_beat(ByteW'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic set_trunc(input bit v);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.trunc = v;
  endtask

  task automatic send_label(input int unsigned n);
    send_beat(CharAt, 1'b0);
    repeat (n) send_beat(rand_label_byte(), 1'b0);
    send_beat(CharNewline, 1'b0);
  endtask

  task automatic send_bases(input int unsigned n);
    repeat (n) send_beat(rand_letter(), 1'b0);
  endtask

  task automatic send_filler(input int unsigned n);
    repeat (n) send_beat(rand_non_nl(), 1'b0);
  endtask

  task automatic send_plus_line(input int unsigned n);
    if (n > 0) begin
      send_beat(($urandom_range(0, 3) != 0) ? CharPlus : rand_non_nl(), 1'b0);
      send_filler(n - 1);
    end
    send_beat(CharNewline, 1'b0);
  endtask

  task automatic send_record(input int unsigned lab, input int unsigned seq,
                             input int unsigned plus);
    send_label(lab);
    send_bases(seq);
    send_beat(CharNewline, 1'b0);
    send_plus_line(plus);
    send_filler(seq);
    send_beat(CharNewline, 1'b0);
  endtask

  task automatic send_directed();
    set_trunc(1'b1);
    send_beat(CharAt, 1'b0);
    send_beat(8'h72, 1'b0);
    send_beat(CharSpace, 1'b0);
    send_beat(8'h71, 1'b0);
    send_beat(CharNewline, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'h7A, 1'b0);
    send_beat(CharNewline, 1'b0);
    send_beat(CharPlus, 1'b0);
    send_beat(CharNewline, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h21, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(CharNewline, 1'b0);
    set_trunc(1'b0);
    send_beat(CharAt, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CharTab, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(CharNewline, 1'b0);
    send_beat(CharNewline, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(CharNewline, 1'b0);
    send_beat(CharNewline, 1'b0);
  endtask

  task automatic send_ending(input ending_e how);
    int unsigned      n;
    int unsigned      m;
    logic [ByteW-1:0] b;
    n = $urandom_range(1, 12);
    case (how)
      EndClean: send_eoi();
      EndOpenQual: begin
        send_label($urandom_range(0, 6));
        send_bases(n);
        send_beat(CharNewline, 1'b0);
        send_plus_line($urandom_range(0, 3));
        send_filler(n);
        send_eoi();
      end
      EndEmptyTail: begin
        repeat ($urandom_range(1, 3)) send_beat(CharNewline, 1'b0);
        send_eoi();
      end
      EndEmptyThenText: begin
        repeat ($urandom_range(1, 3)) send_beat(CharNewline, 1'b0);
        send_beat(rand_non_nl(), 1'b0);
      end
      EndNoAt: begin
        b = rand_non_nl();
        while (b == CharAt) b = rand_non_nl();
        send_beat(b, 1'b0);
      end
      EndBadLetter: begin
        send_label($urandom_range(0, 6));
        send_bases($urandom_range(0, 5));
        b = ByteW'($urandom_range(8'h20, 8'h7E));
        while (sb.is_letter(b)) b = ByteW'($urandom_range(8'h20, 8'h7E));
        send_beat(b, 1'b0);
      end
      EndNonPrint: begin
        send_label($urandom_range(0, 6));
        send_bases($urandom_range(0, 5));
        b = rand_non_nl();
        while (b >= 8'h20 && b <= 8'h7E) b = rand_non_nl();
        send_beat(b, 1'b0);
      end
      EndEarlyEof: begin
        m = $urandom_range(0, 3);
        if (m == 0) begin
          send_beat(CharAt, 1'b0);
          repeat ($urandom_range(0, 4)) send_beat(rand_label_byte(), 1'b0);
        end else begin
          send_label($urandom_range(0, 4));
          send_bases(n);
          if (m >= 2) begin
            send_beat(CharNewline, 1'b0);
            if (m == 2) send_filler($urandom_range(0, 3));
            else send_plus_line($urandom_range(0, 3));
          end
        end
        send_eoi();
      end
      EndLength: begin
        send_label($urandom_range(0, 4));
        send_bases(n);
        send_beat(CharNewline, 1'b0);
        send_plus_line($urandom_range(0, 3));
        m = $urandom_range(0, n + 3);
        if (m == n) m = n + 1;
        send_filler(m);
        if ($urandom_range(0, 1) == 0) send_beat(CharNewline, 1'b0);
        else send_eoi();
      end
      default: send_eoi();
    endcase
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    recv_quiet = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int unsigned stall;
      stall = recv_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
    end
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned seq;
    int unsigned drain;
    sb = new();
    beats_sent = 0;
    send_quiet = 1'b0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_data            <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.byte_value   <= '0;
    in_bus.end_of_input <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();

    while (beats_sent < RandomBeats) begin
      if ($urandom_range(0, 3) == 0) set_trunc($urandom_range(0, 1));
      seq = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20);
      send_record($urandom_range(0, 12), seq, $urandom_range(0, 6));
    end

    send_ending(ending_e'($urandom_range(0, 8)));
    repeat (NoiseBeats) send_beat(ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (sb.pending.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- fastq_record_parser.f -----
design/frp_pkg.sv
design/frp_if.sv
design/frp_in_reg.sv
design/frp_parse.sv
design/fastq_record_parser.sv
bench/tb_fastq_record_parser.sv
